[rtl/cpio_newc_header_parser_unit_assert.svh]
// Assertion helpers, clocked on clk and disabled while rst is high.
`ifndef CPIO_NEWC_HEADER_PARSER_UNIT_ASSERT_SVH
`define CPIO_NEWC_HEADER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CPIO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CPIO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cpio_pkg.sv]
package cpio_pkg;

  localparam int PosW      = 7;
  localparam int MagicLen  = 6;
  localparam int HdrLen    = 110;
  localparam int IdxHdrLen = 16;
  localparam int IdxDigEnd = MagicLen + 8;
  localparam int FieldCnt  = 13;
  localparam int SlotCnt   = 6;
  localparam int SlotW     = $clog2(SlotCnt);
  localparam int NameW     = 13;
  localparam int IdxW      = 16;
  localparam int StatusW   = 3;
  localparam int PaddrW    = 4;
  localparam int PdataW    = 32;

  localparam logic [31:0] NameLenMax    = 32'd4096;
  localparam logic [31:0] NameLenMaxSrc = 32'd257;
  localparam logic [31:0] Mask16        = 32'h0000_ffff;

  // magic match flags: bit 1 indexed, bit 0 regular
  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindReg  = 2'd1;
  localparam logic [1:0] KindIdx  = 2'd2;
  localparam logic [1:0] KindBoth = 2'd3;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StBadMagic = 3'd1;
  localparam logic [StatusW-1:0] StBadHex   = 3'd2;
  localparam logic [StatusW-1:0] StBadMode  = 3'd3;
  localparam logic [StatusW-1:0] StBadNlink = 3'd4;
  localparam logic [StatusW-1:0] StBadName  = 3'd5;

  localparam logic [1:0] RegSrcPkg   = 2'd0;
  localparam logic [1:0] RegIdxEn    = 2'd1;
  localparam logic [1:0] RegEntryCnt = 2'd2;

  // stored field slots
  localparam logic [SlotW-1:0] SlotInode = 3'd0;
  localparam logic [SlotW-1:0] SlotMode  = 3'd1;
  localparam logic [SlotW-1:0] SlotNlink = 3'd2;
  localparam logic [SlotW-1:0] SlotMtime = 3'd3;
  localparam logic [SlotW-1:0] SlotSize  = 3'd4;
  localparam logic [SlotW-1:0] SlotName  = 3'd5;

  typedef struct packed {
    logic               entry_kind;
    logic [31:0]        inode;
    logic [15:0]        file_mode;
    logic [15:0]        link_count;
    logic [31:0]        mod_time;
    logic [31:0]        file_size;
    logic [NameW-1:0]   name_length;
    logic [NameW-1:0]   name_read_bytes;
    logic [IdxW-1:0]    entry_index;
    logic [StatusW-1:0] status;
  } info_t;

  typedef struct packed {
    logic             keep;
    logic [SlotW-1:0] slot;
  } slot_t;

  function automatic logic [7:0] magic_char(input logic idx, input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h30;
      3'd1:    c = 8'h37;
      3'd2:    c = 8'h30;
      3'd3:    c = 8'h37;
      3'd4:    c = 8'h30;
      3'd5:    c = idx ? 8'h58 : 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // hex digit decode; bit 4 set when the byte is a valid digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] d;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = {1'b1, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      d = {1'b1, b[3:0] + 4'd9};
    end else begin
      d = 5'd0;
    end
    return d;
  endfunction

  function automatic slot_t slot_of(input logic [3:0] f);
    slot_t s;
    case (f)
      4'd0:    s = '{keep: 1'b1, slot: SlotInode};
      4'd1:    s = '{keep: 1'b1, slot: SlotMode};
      4'd4:    s = '{keep: 1'b1, slot: SlotNlink};
      4'd5:    s = '{keep: 1'b1, slot: SlotMtime};
      4'd6:    s = '{keep: 1'b1, slot: SlotSize};
      4'd11:   s = '{keep: 1'b1, slot: SlotName};
      default: s = '{keep: 1'b0, slot: SlotInode};
    endcase
    return s;
  endfunction

endpackage

[rtl/cpio_ifs.sv]
interface cpio_hdr_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       header_start;

  modport source (output valid, data_byte, header_start, input ready);
  modport sink (input valid, data_byte, header_start, output ready);
endinterface

interface cpio_info_if;
  logic                         valid;
  logic                         ready;
  logic                         entry_kind;
  logic [31:0]                  inode;
  logic [15:0]                  file_mode;
  logic [15:0]                  link_count;
  logic [31:0]                  mod_time;
  logic [31:0]                  file_size;
  logic [cpio_pkg::NameW-1:0]   name_length;
  logic [cpio_pkg::NameW-1:0]   name_read_bytes;
  logic [cpio_pkg::IdxW-1:0]    entry_index;
  logic [cpio_pkg::StatusW-1:0] status;

  modport source (output valid, entry_kind, inode, file_mode, link_count, mod_time,
                  file_size, name_length, name_read_bytes, entry_index, status,
                  input ready);
  modport sink (input valid, entry_kind, inode, file_mode, link_count, mod_time,
                file_size, name_length, name_read_bytes, entry_index, status,
                output ready);
endinterface

[rtl/cpio_newc_header_parser_unit.sv]
// cpio newc header parser.
// hdr: one header byte per beat; header_start marks the first magic byte and
//   restarts parsing, dropping any header in progress. Bytes seen after a
//   result and before the next header_start are consumed and ignored.
// info: one beat per header: after byte 110 of a 070701 header, byte 16 of
//   a 07070X header, or byte 6 when the magic is bad. Fields other than
//   status are zero on a failed header.
// The result beat is registered in the output register (in the skid entry if
//   info stalls). Throughput: one byte per cycle while hdr is ready; each byte
//   costs one hex decode, a 4-bit accumulator shift and end-of-header checks.
// A two-entry result buffer (output register plus skid) sits on info. hdr
//   stays ready while info is stalled until the skid entry holds a result,
//   then waits for info to drain.
// Reset: synchronous rst clears the parser to wait for header_start, empties
//   the result buffer and zeroes the APB registers (source_package at 0x0,
//   index_entries_enabled at 0x4, entry_count at 0x8). Write them only while
//   the parser is idle.
`include "cpio_newc_header_parser_unit_assert.svh"

module cpio_newc_header_parser_unit (
  input  logic                          clk,
  input  logic                          rst,
  cpio_hdr_if.sink                      hdr,
  cpio_info_if.source                   info,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cpio_pkg::PaddrW-1:0]   paddr,
  input  logic [cpio_pkg::PdataW-1:0]   pwdata,
  output logic [cpio_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  localparam logic [cpio_pkg::PosW-1:0] MagicLast = 7'(cpio_pkg::MagicLen - 1);
  localparam logic [cpio_pkg::PosW-1:0] MagicLen  = 7'(cpio_pkg::MagicLen);
  localparam logic [cpio_pkg::PosW-1:0] IdxDigEnd = 7'(cpio_pkg::IdxDigEnd);
  localparam logic [cpio_pkg::PosW-1:0] IdxLast   = 7'(cpio_pkg::IdxHdrLen - 1);
  localparam logic [cpio_pkg::PosW-1:0] HdrLast   = 7'(cpio_pkg::HdrLen - 1);

  // configuration
  logic        source_package;
  logic        index_en;
  logic [15:0] entry_count;

  // parser state
  logic [cpio_pkg::PosW-1:0] pos, pos_next;
  logic [31:0]               hacc, hacc_next;
  logic [1:0]                kind, kind_next;
  logic                      fault, fault_next;
  logic                      stopped, stopped_next;
  logic [31:0]               fv [cpio_pkg::SlotCnt];

  // working values for the current beat
  logic [cpio_pkg::PosW-1:0] cur_pos;
  logic [31:0]               cur_acc;
  logic [1:0]                cur_kind;
  logic                      cur_fault;
  logic                      cur_stop;
  logic [4:0]                digit;
  logic [31:0]               shifted;
  logic                      fault_d;
  logic [cpio_pkg::PosW-1:0] off;
  cpio_pkg::slot_t           sl;
  logic                      fv_we;
  logic [31:0]               name_m1;
  logic [31:0]               name_max;
  logic [cpio_pkg::NameW-1:0] name_pad;

  cpio_pkg::info_t res;
  logic            res_hit;
  logic            hdr_fire;

  // result buffer
  cpio_pkg::info_t out_q, skid_q;
  logic            out_v, skid_v;
  logic            out_fire;

  assign pready   = 1'b1;
  assign hdr.ready = !skid_v;
  assign hdr_fire  = hdr.valid && hdr.ready;
  assign out_fire  = out_v && info.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_package <= 1'b0;
      index_en       <= 1'b0;
      entry_count    <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        cpio_pkg::RegSrcPkg:   source_package <= pwdata[0];
        cpio_pkg::RegIdxEn:    index_en       <= pwdata[0];
        cpio_pkg::RegEntryCnt: entry_count    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cpio_pkg::RegSrcPkg:   prdata = {31'd0, source_package};
      cpio_pkg::RegIdxEn:    prdata = {31'd0, index_en};
      cpio_pkg::RegEntryCnt: prdata = {16'd0, entry_count};
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    cur_pos   = hdr.header_start ? '0 : pos;
    cur_acc   = hdr.header_start ? '0 : hacc;
    cur_kind  = hdr.header_start ? cpio_pkg::KindBoth : kind;
    cur_fault = hdr.header_start ? 1'b0 : fault;
    cur_stop  = hdr.header_start ? 1'b0 : stopped;
    digit     = cpio_pkg::hex_digit(hdr.data_byte);
    shifted   = {cur_acc[27:0], digit[3:0]};
    fault_d   = cur_fault | !digit[4];
    off       = cur_pos - MagicLen;
    sl        = cpio_pkg::slot_of(off[6:3]);
    name_m1   = fv[cpio_pkg::SlotName] - 32'd1;
    name_max  = source_package ? cpio_pkg::NameLenMaxSrc : cpio_pkg::NameLenMax;
    name_pad  = 13'd2 + ((name_m1[12:0] + 13'd2) & ~13'd3);

    pos_next     = pos;
    hacc_next    = hacc;
    kind_next    = kind;
    fault_next   = fault;
    stopped_next = stopped;
    fv_we        = 1'b0;
    res          = '0;
    res_hit      = 1'b0;

    if (hdr_fire) begin
      hacc_next    = cur_acc;
      kind_next    = cur_kind;
      fault_next   = cur_fault;
      stopped_next = cur_stop;
      pos_next     = cur_pos;
      if (!cur_stop) begin
        pos_next = cur_pos + 7'd1;
        if (cur_pos < MagicLen) begin
          kind_next = cur_kind &
            {hdr.data_byte == cpio_pkg::magic_char(1'b1, cur_pos[2:0]),
             hdr.data_byte == cpio_pkg::magic_char(1'b0, cur_pos[2:0])};
          if (cur_pos == MagicLast) begin
            if (!index_en) begin
              kind_next[1] = 1'b0;
            end
            if (kind_next == cpio_pkg::KindNone) begin
              res.status   = cpio_pkg::StBadMagic;
              res_hit      = 1'b1;
              stopped_next = 1'b1;
            end
          end
        end else if (cur_kind == cpio_pkg::KindIdx) begin
          if (cur_pos < IdxDigEnd) begin
            hacc_next  = shifted;
            fault_next = fault_d;
          end else if (cur_pos == IdxLast) begin
            res_hit      = 1'b1;
            stopped_next = 1'b1;
            if (cur_fault) begin
              res.status = cpio_pkg::StBadHex;
            end else if (cur_acc >= {16'd0, entry_count}) begin
              res.status = cpio_pkg::StBadName;
            end else begin
              res.status      = cpio_pkg::StOk;
              res.entry_kind  = 1'b1;
              res.entry_index = cur_acc[15:0];
            end
          end
        end else begin
          hacc_next  = shifted;
          fault_next = fault_d;
          if (off[2:0] == 3'd7) begin
            hacc_next = '0;
            fv_we     = sl.keep;
          end
          if (cur_pos == HdrLast) begin
            res_hit      = 1'b1;
            stopped_next = 1'b1;
            if (fault_d) begin
              res.status = cpio_pkg::StBadHex;
            end else if (|fv[cpio_pkg::SlotMode][31:16]) begin
              res.status = cpio_pkg::StBadMode;
            end else if (|fv[cpio_pkg::SlotNlink][31:16]) begin
              res.status = cpio_pkg::StBadNlink;
            end else if (name_m1 == 32'd0 || name_m1 > name_max) begin
              res.status = cpio_pkg::StBadName;
            end else begin
              res.status          = cpio_pkg::StOk;
              res.inode           = fv[cpio_pkg::SlotInode];
              res.file_mode       = fv[cpio_pkg::SlotMode][15:0];
              res.link_count      = fv[cpio_pkg::SlotNlink][15:0];
              res.mod_time        = fv[cpio_pkg::SlotMtime];
              res.file_size       = fv[cpio_pkg::SlotSize];
              res.name_length     = name_m1[12:0];
              res.name_read_bytes = name_pad;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      hacc    <= '0;
      kind    <= cpio_pkg::KindNone;
      fault   <= 1'b0;
      stopped <= 1'b1;
    end else begin
      pos     <= pos_next;
      hacc    <= hacc_next;
      kind    <= kind_next;
      fault   <= fault_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fv_we) begin
      fv[sl.slot] <= shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || out_fire) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= res_hit;
      end
    end else if (res_hit) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || out_fire) begin
      out_q <= skid_v ? skid_q : res;
    end else if (res_hit) begin
      skid_q <= res;
    end
  end

  assign info.valid           = out_v;
  assign info.entry_kind      = out_q.entry_kind;
  assign info.inode           = out_q.inode;
  assign info.file_mode       = out_q.file_mode;
  assign info.link_count      = out_q.link_count;
  assign info.mod_time        = out_q.mod_time;
  assign info.file_size       = out_q.file_size;
  assign info.name_length     = out_q.name_length;
  assign info.name_read_bytes = out_q.name_read_bytes;
  assign info.entry_index     = out_q.entry_index;
  assign info.status          = out_q.status;

  `CPIO_ASSERT_NOW(a_skid_behind_out, skid_v, out_v,
    "skid entry held while output register empty")
  `CPIO_ASSERT_NOW(a_pos_in_header, !stopped, pos <= HdrLast,
    "byte position ran past the header end")
  `CPIO_ASSERT_NEXT(a_stopped_hold, hdr_fire && stopped && !hdr.header_start,
    stopped && pos == $past(pos) && !skid_v || stopped && pos == $past(pos),
    "ignored byte changed parser state")
  `CPIO_ASSERT_NOW(a_fail_zero, out_v && out_q.status != cpio_pkg::StOk,
    out_q.entry_kind == 1'b0 && out_q.inode == '0 && out_q.file_size == '0
    && out_q.entry_index == '0 && out_q.name_length == '0,
    "failed header carries nonzero fields")

endmodule
